// ===== hw/rtl/dcd_pkg.sv =====
// Shared types, codes and widths for the DMA channel dispatcher.
`timescale 1ns / 1ps

package dcd_pkg;

    localparam int DEF_NUM_CHANNELS = 2;
    localparam int DEF_QUEUE_DEPTH  = 16;

    localparam int CHAN_W  = 3;
    localparam int TAG_W   = 32;
    localparam int LEN_W   = 26;
    localparam int BYTES_W = 32;
    localparam int TOTAL_W = 48;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 3;

    typedef enum logic [0:0] {
        ACT_SUBMIT = 1'b0,
        ACT_IRQ    = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        OUT_QUEUED       = 3'd0,
        OUT_REFUSED_ERR  = 3'd1,
        OUT_REFUSED_FULL = 3'd2,
        OUT_BUSY_ACK     = 3'd3,
        OUT_SPURIOUS     = 3'd4,
        OUT_DONE_OK      = 3'd5,
        OUT_DONE_ERR     = 3'd6
    } outcome_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_ERR  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_EXEC,
        S_LAUNCH,
        S_PUSH
    } state_t;

    // configuration register indexes
    localparam logic CFG_FIRST_CHANNEL = 1'b0;
    localparam logic CFG_LAST_CHANNEL  = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } qentry_t;

    typedef struct packed {
        logic              start;
        logic [CHAN_W-1:0] start_idx;
        logic [CHAN_W-1:0] lo;
        logic [CHAN_W-1:0] hi;
    } scan_ctl_t;

    typedef struct packed {
        logic              last;
        logic [CHAN_W-1:0] idx;
        logic [CHAN_W-1:0] winner;
    } scan_stat_t;

endpackage

// ===== hw/rtl/dma_channel_dispatcher.sv =====
// Top level of the DMA channel dispatcher: sequencer, per-channel state and result register.
`timescale 1ns / 1ps

// One word at a time. A submit word walks channels first..last through a single
// byte-count comparator, one channel per cycle after a look at the rotating
// candidate, then reads the queue head and updates the channel. An interrupt
// word reads the queue head and updates, with a second queue read when the next
// queued transfer is launched. The queue memory has one read port with
// registered data; that port sets the interrupt path. The result sits in an
// output register; in_ready returns once it is loaded, so a stalled result
// holds at most the next word. Queue storage has no reset and needs no
// clearing pass: only entries that were written are ever read.
// Configuration may be written only while no word is in flight.
module dma_channel_dispatcher
    import dcd_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [TAG_W-1:0]   transfer_tag,
    input  logic [LEN_W-1:0]   transfer_length,
    input  logic [CHAN_W-1:0]  irq_channel,
    input  logic               still_busy,
    input  logic               segment_done,
    input  logic               chain_done,
    input  logic               bus_error,
    input  logic               memory_error,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         outcome,
    output logic [CHAN_W-1:0]  channel,
    output logic [TAG_W-1:0]   done_tag,
    output logic               started,
    output logic [TAG_W-1:0]   start_tag,
    output logic [1:0]         channel_status,
    output logic [BYTES_W-1:0] queued_bytes,
    output logic [TOTAL_W-1:0] transferred_bytes,
    output logic [CNT_W-1:0]   errors_seen,
    output logic [CNT_W-1:0]   spurious_seen,
    output logic [CNT_W-1:0]   segments_seen,
    output logic [CNT_W-1:0]   chains_seen
);

    localparam int CW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int HW      = $clog2(QUEUE_DEPTH);
    localparam int FW      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = NUM_CHANNELS * QUEUE_DEPTH;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // sequencer
    state_t state_reg, state_next;

    // configuration and rotation
    logic [CHAN_W-1:0] first_reg, first_next;
    logic [CHAN_W-1:0] last_reg, last_next;
    logic [CHAN_W-1:0] rot_reg, rot_next;

    // captured word
    action_t           action_reg, action_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CHAN_W-1:0] irq_reg, irq_next;
    logic              busy_f_reg, busy_f_next;
    logic              seg_f_reg, seg_f_next;
    logic              chain_f_reg, chain_f_next;
    logic              err_f_reg, err_f_next;
    logic [CHAN_W-1:0] c_reg, c_next;

    // per-channel state
    mode_t              mode_reg  [NUM_CHANNELS];
    mode_t              mode_next [NUM_CHANNELS];
    logic [BYTES_W-1:0] pend_reg  [NUM_CHANNELS];
    logic [BYTES_W-1:0] pend_next [NUM_CHANNELS];
    logic [HW-1:0]      head_reg  [NUM_CHANNELS];
    logic [HW-1:0]      head_next [NUM_CHANNELS];
    logic [FW-1:0]      fill_reg  [NUM_CHANNELS];
    logic [FW-1:0]      fill_next [NUM_CHANNELS];
    logic [TOTAL_W-1:0] sent_reg  [NUM_CHANNELS];
    logic [TOTAL_W-1:0] sent_next [NUM_CHANNELS];
    logic [CNT_W-1:0]   cerr_reg  [NUM_CHANNELS];
    logic [CNT_W-1:0]   cerr_next [NUM_CHANNELS];
    logic [CNT_W-1:0]   cspur_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]   cspur_next[NUM_CHANNELS];
    logic [CNT_W-1:0]   cseg_reg  [NUM_CHANNELS];
    logic [CNT_W-1:0]   cseg_next [NUM_CHANNELS];
    logic [CNT_W-1:0]   cchn_reg  [NUM_CHANNELS];
    logic [CNT_W-1:0]   cchn_next [NUM_CHANNELS];

    // result under construction
    outcome_t          res_outcome_reg, res_outcome_next;
    logic [TAG_W-1:0]  res_done_tag_reg, res_done_tag_next;
    logic              res_started_reg, res_started_next;
    logic [TAG_W-1:0]  res_start_tag_reg, res_start_tag_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    outcome_t           outcome_reg, outcome_next;
    logic [CHAN_W-1:0]  channel_reg, channel_next;
    logic [TAG_W-1:0]   done_tag_reg, done_tag_next;
    logic               started_reg, started_next;
    logic [TAG_W-1:0]   start_tag_reg, start_tag_next;
    mode_t              status_reg, status_next;
    logic [BYTES_W-1:0] queued_reg, queued_next;
    logic [TOTAL_W-1:0] xfer_reg, xfer_next;
    logic [CNT_W-1:0]   errors_reg, errors_next;
    logic [CNT_W-1:0]   spurious_reg, spurious_next;
    logic [CNT_W-1:0]   segments_reg, segments_next;
    logic [CNT_W-1:0]   chains_reg, chains_next;

    // datapath helpers
    logic [CHAN_W-1:0] lo, hi, cand;
    logic [CHAN_W-1:0] cur_chan, rd_chan;
    logic [CW-1:0]     rci;
    logic              in_fire, out_free, missing, irq_launch;
    mode_t             mode_rd;
    logic [BYTES_W-1:0] pend_rd;
    logic [HW-1:0]     head_rd, head_adv, slot;
    logic [FW-1:0]     fill_rd;
    logic [HW:0]       slot_sum;

    scan_ctl_t  scan_ctl;
    scan_stat_t scan_stat;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    qentry_t       mem_wdata, mem_rdata;

    function automatic logic [AW-1:0] qaddr(input logic [CW-1:0] ch, input logic [HW-1:0] ix);
        return AW'(ch) * AW'(QUEUE_DEPTH) + AW'(ix);
    endfunction

    // ---------------------------------------------------------------- helpers
    assign in_fire  = in_valid & in_ready;
    assign out_free = ~out_valid_reg | out_ready;

    // clamp the dispatch range to the channels that exist
    assign hi   = ({1'b0, last_reg} > 4'(NUM_CHANNELS - 1)) ? CHAN_W'(NUM_CHANNELS - 1)
                                                              : last_reg;
    assign lo   = (first_reg > hi) ? hi : first_reg;
    assign cand = (rot_reg < lo || rot_reg > hi) ? lo : rot_reg;

    assign missing  = ({1'b0, irq_reg} >= 4'(NUM_CHANNELS));
    assign cur_chan = (action_reg == ACT_IRQ) ? irq_reg : scan_stat.winner;

    // single channel read port: scan index while scanning, else the working channel
    always_comb
    begin
        case (state_reg)
            S_SCAN:  rd_chan = scan_stat.idx;
            S_READ:  rd_chan = cur_chan;
            default: rd_chan = c_reg;
        endcase
    end

    assign rci     = rd_chan[CW-1:0];
    assign mode_rd = mode_reg[rci];
    assign pend_rd = pend_reg[rci];
    assign head_rd = head_reg[rci];
    assign fill_rd = fill_reg[rci];

    assign head_adv = (head_rd == HW'(QUEUE_DEPTH - 1)) ? '0 : head_rd + 1'b1;
    assign slot_sum = (HW + 1)'(head_rd) + (HW + 1)'(fill_rd);
    assign slot     = (slot_sum >= (HW + 1)'(QUEUE_DEPTH))
                      ? HW'(slot_sum - (HW + 1)'(QUEUE_DEPTH)) : HW'(slot_sum);

    // ok completion with more queued: launch the next entry after a second read
    assign irq_launch = (action_reg == ACT_IRQ) && !missing && !busy_f_reg &&
                        !err_f_reg && (fill_rd != '0) && (fill_rd != FW'(1));

    assign scan_ctl.start     = in_fire && (action == ACT_SUBMIT);
    assign scan_ctl.start_idx = cand;
    assign scan_ctl.lo        = lo;
    assign scan_ctl.hi        = hi;

    assign mem_raddr = (state_reg == S_READ) ? qaddr(rci, head_rd) : qaddr(rci, head_adv);
    assign mem_waddr = qaddr(rci, slot);
    assign mem_wdata = '{tag: tag_reg, len: len_reg};

    // ---------------------------------------------------------------- units
    dcd_min_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .value (pend_rd),
        .stat  (scan_stat)
    );

    dcd_queue_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_qmem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = (action == ACT_SUBMIT) ? S_SCAN : S_READ;
            end
            S_SCAN:
            begin
                if (scan_stat.last)
                    state_next = S_READ;
            end
            S_READ:   state_next = S_EXEC;
            S_EXEC:   state_next = irq_launch ? S_LAUNCH : S_PUSH;
            S_LAUNCH: state_next = S_PUSH;
            S_PUSH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath control
    always_comb
    begin
        first_next   = first_reg;
        last_next    = last_reg;
        rot_next     = rot_reg;
        action_next  = action_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        irq_next     = irq_reg;
        busy_f_next  = busy_f_reg;
        seg_f_next   = seg_f_reg;
        chain_f_next = chain_f_reg;
        err_f_next   = err_f_reg;
        c_next       = c_reg;

        mode_next  = mode_reg;
        pend_next  = pend_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        sent_next  = sent_reg;
        cerr_next  = cerr_reg;
        cspur_next = cspur_reg;
        cseg_next  = cseg_reg;
        cchn_next  = cchn_reg;

        res_outcome_next   = res_outcome_reg;
        res_done_tag_next  = res_done_tag_reg;
        res_started_next   = res_started_reg;
        res_start_tag_next = res_start_tag_reg;

        out_valid_next = out_valid_reg;
        outcome_next   = outcome_reg;
        channel_next   = channel_reg;
        done_tag_next  = done_tag_reg;
        started_next   = started_reg;
        start_tag_next = start_tag_reg;
        status_next    = status_reg;
        queued_next    = queued_reg;
        xfer_next      = xfer_reg;
        errors_next    = errors_reg;
        spurious_next  = spurious_reg;
        segments_next  = segments_reg;
        chains_next    = chains_reg;

        mem_we = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_FIRST_CHANNEL: first_next = cfg_data;
                CFG_LAST_CHANNEL:  last_next  = cfg_data;
                default:           first_next = first_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    action_next  = action_t'(action);
                    tag_next     = transfer_tag;
                    len_next     = transfer_length;
                    irq_next     = irq_channel;
                    busy_f_next  = still_busy;
                    seg_f_next   = segment_done;
                    chain_f_next = chain_done;
                    err_f_next   = bus_error | memory_error;
                    // candidate advances even if the submit is refused
                    if (action == ACT_SUBMIT)
                        rot_next = (cand >= hi) ? lo : cand + 3'd1;
                end
            end

            S_READ:
            begin
                c_next = cur_chan;
            end

            S_EXEC:
            begin
                res_done_tag_next  = '0;
                res_started_next   = 1'b0;
                res_start_tag_next = '0;
                if (action_reg == ACT_SUBMIT)
                begin
                    if (mode_rd == MODE_ERR)
                        res_outcome_next = OUT_REFUSED_ERR;
                    else if (fill_rd == FW'(QUEUE_DEPTH))
                        res_outcome_next = OUT_REFUSED_FULL;
                    else
                    begin
                        mem_we           = 1'b1;
                        fill_next[rci]   = fill_rd + FW'(1);
                        pend_next[rci]   = pend_rd + BYTES_W'(len_reg);
                        res_outcome_next = OUT_QUEUED;
                        if (mode_rd == MODE_IDLE)
                        begin
                            mode_next[rci]     = MODE_RUN;
                            res_started_next   = 1'b1;
                            // empty queue: the head is the word being written now
                            res_start_tag_next = (fill_rd == '0) ? tag_reg : mem_rdata.tag;
                        end
                    end
                end
                else if (missing)
                    res_outcome_next = OUT_SPURIOUS;
                else if (busy_f_reg)
                begin
                    mode_next[rci] = MODE_RUN;
                    if (seg_f_reg)
                        cseg_next[rci] = cseg_reg[rci] + 1'b1;
                    else
                        cspur_next[rci] = cspur_reg[rci] + 1'b1;
                    res_outcome_next = OUT_BUSY_ACK;
                end
                else
                begin
                    if (err_f_reg)
                    begin
                        cerr_next[rci] = cerr_reg[rci] + 1'b1;
                        mode_next[rci] = MODE_ERR;
                    end
                    else
                        mode_next[rci] = MODE_IDLE;
                    if (seg_f_reg)
                        cseg_next[rci] = cseg_reg[rci] + 1'b1;
                    if (chain_f_reg)
                        cchn_next[rci] = cchn_reg[rci] + 1'b1;

                    if (fill_rd == '0)
                    begin
                        cspur_next[rci]  = cspur_reg[rci] + 1'b1;
                        mode_next[rci]   = MODE_IDLE;
                        res_outcome_next = OUT_SPURIOUS;
                    end
                    else
                    begin
                        res_done_tag_next = mem_rdata.tag;
                        head_next[rci]    = head_adv;
                        fill_next[rci]    = fill_rd - FW'(1);
                        pend_next[rci]    = pend_rd - BYTES_W'(mem_rdata.len);
                        if (err_f_reg)
                            res_outcome_next = OUT_DONE_ERR;
                        else
                        begin
                            sent_next[rci]   = sent_reg[rci] + TOTAL_W'(mem_rdata.len);
                            res_outcome_next = OUT_DONE_OK;
                            if (irq_launch)
                            begin
                                mode_next[rci]   = MODE_RUN;
                                res_started_next = 1'b1;
                            end
                        end
                    end
                end
            end

            S_LAUNCH:
            begin
                res_start_tag_next = mem_rdata.tag;
            end

            S_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    outcome_next   = res_outcome_reg;
                    channel_next   = c_reg;
                    done_tag_next  = res_done_tag_reg;
                    started_next   = res_started_reg;
                    start_tag_next = res_start_tag_reg;
                    if (action_reg == ACT_IRQ && missing)
                    begin
                        status_next   = MODE_IDLE;
                        queued_next   = '0;
                        xfer_next     = '0;
                        errors_next   = '0;
                        spurious_next = '0;
                        segments_next = '0;
                        chains_next   = '0;
                    end
                    else
                    begin
                        status_next   = mode_rd;
                        queued_next   = pend_rd;
                        xfer_next     = sent_reg[rci];
                        errors_next   = cerr_reg[rci];
                        spurious_next = cspur_reg[rci];
                        segments_next = cseg_reg[rci];
                        chains_next   = cchn_reg[rci];
                    end
                end
            end

            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 3'd0;
            last_reg      <= 3'd1;
            rot_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                mode_reg[i]  <= MODE_IDLE;
                pend_reg[i]  <= '0;
                head_reg[i]  <= '0;
                fill_reg[i]  <= '0;
                sent_reg[i]  <= '0;
                cerr_reg[i]  <= '0;
                cspur_reg[i] <= '0;
                cseg_reg[i]  <= '0;
                cchn_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            rot_reg       <= rot_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            pend_reg      <= pend_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            sent_reg      <= sent_next;
            cerr_reg      <= cerr_next;
            cspur_reg     <= cspur_next;
            cseg_reg      <= cseg_next;
            cchn_reg      <= cchn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg        <= action_next;
        tag_reg           <= tag_next;
        len_reg           <= len_next;
        irq_reg           <= irq_next;
        busy_f_reg        <= busy_f_next;
        seg_f_reg         <= seg_f_next;
        chain_f_reg       <= chain_f_next;
        err_f_reg         <= err_f_next;
        c_reg             <= c_next;
        res_outcome_reg   <= res_outcome_next;
        res_done_tag_reg  <= res_done_tag_next;
        res_started_reg   <= res_started_next;
        res_start_tag_reg <= res_start_tag_next;
        outcome_reg       <= outcome_next;
        channel_reg       <= channel_next;
        done_tag_reg      <= done_tag_next;
        started_reg       <= started_next;
        start_tag_reg     <= start_tag_next;
        status_reg        <= status_next;
        queued_reg        <= queued_next;
        xfer_reg          <= xfer_next;
        errors_reg        <= errors_next;
        spurious_reg      <= spurious_next;
        segments_reg      <= segments_next;
        chains_reg        <= chains_next;
    end

    // ---------------------------------------------------------------- ports
    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign outcome           = outcome_reg;
    assign channel           = channel_reg;
    assign done_tag          = done_tag_reg;
    assign started           = started_reg;
    assign start_tag         = start_tag_reg;
    assign channel_status    = status_reg;
    assign queued_bytes      = queued_reg;
    assign transferred_bytes = xfer_reg;
    assign errors_seen       = errors_reg;
    assign spurious_seen     = spurious_reg;
    assign segments_seen     = segments_reg;
    assign chains_seen       = chains_reg;

    // ---------------------------------------------------------------- checks
    // the comparator only ever looks at channels inside the clamped range
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_stat.idx >= lo && scan_stat.idx <= hi))
        else $error("scan index outside dispatch range");

    // queue writes come only from the update step of a submit
    a_write_on_submit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_EXEC && action_reg == ACT_SUBMIT))
        else $error("queue written outside submit update");

    // a launch always leaves the channel running
    a_started_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && started) |-> (channel_status == MODE_RUN))
        else $error("launch reported on a channel that is not running");

    // refusal for an error-stopped channel reports that state
    a_refused_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome == OUT_REFUSED_ERR) |-> (channel_status == MODE_ERR))
        else $error("error refusal on a channel not error-stopped");

endmodule

// ===== hw/rtl/dcd_min_scan.sv =====
// Shared compare unit: walks channels one per cycle, keeps the smallest byte count.
`timescale 1ns / 1ps

module dcd_min_scan
    import dcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scan_ctl_t          ctl,
    input  logic [BYTES_W-1:0] value,
    output scan_stat_t         stat
);

    logic               busy_reg, busy_next;
    logic               first_reg, first_next;
    logic [CHAN_W-1:0]  idx_reg, idx_next;
    logic [CHAN_W-1:0]  win_reg, win_next;
    logic [BYTES_W-1:0] best_reg, best_next;

    always_comb
    begin
        busy_next  = busy_reg;
        first_next = first_reg;
        idx_next   = idx_reg;
        win_next   = win_reg;
        best_next  = best_reg;
        if (ctl.start)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            idx_next   = ctl.start_idx;
        end
        else if (busy_reg)
        begin
            if (first_reg)
            begin
                // candidate seeds the minimum, so it wins ties
                best_next  = value;
                win_next   = idx_reg;
                idx_next   = ctl.lo;
                first_next = 1'b0;
            end
            else
            begin
                if (value < best_reg)
                begin
                    best_next = value;
                    win_next  = idx_reg;
                end
                if (idx_reg == ctl.hi)
                    busy_next = 1'b0;
                else
                    idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        win_reg  <= win_next;
        best_reg <= best_next;
    end

    assign stat.last   = busy_reg & ~first_reg & (idx_reg == ctl.hi);
    assign stat.idx    = idx_reg;
    assign stat.winner = win_reg;

endmodule

// ===== hw/rtl/dcd_queue_mem.sv =====
// Transfer queue storage for all channels, one write and one registered read port.
`timescale 1ns / 1ps

module dcd_queue_mem
    import dcd_pkg::*;
#(
    parameter int ENTRIES = DEF_NUM_CHANNELS * DEF_QUEUE_DEPTH,
    parameter int AW      = $clog2(DEF_NUM_CHANNELS * DEF_QUEUE_DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  qentry_t       wdata,
    input  logic [AW-1:0] raddr,
    output qentry_t       rdata
);

    qentry_t mem [ENTRIES];
    qentry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
